// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, disabled while reset is low.
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spr_pkg.sv =====
package spr_pkg;

  // Frame layout and marker bytes.
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned CntW       = $clog2(FrameBytes);
  localparam logic [7:0]  CmdByte    = 8'h36;
  localparam logic [7:0]  TailByte   = 8'h6B;
  localparam logic [7:0]  NegFlag    = 8'h01;

  // Angle format: position times 360, a signed 41-bit integer in degrees.
  localparam int unsigned PosW   = 32;
  localparam int unsigned AngleW = 41;
  localparam logic signed [AngleW-1:0] DegScale = 41'sd360;

  // Configuration register map.
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [7:0] YawAddrReset   = 8'd1;
  localparam logic [7:0] PitchAddrReset = 8'd2;

  typedef enum logic {
    RegYawAddr   = 1'b0,
    RegPitchAddr = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    HitNone  = 2'd0,
    HitYaw   = 2'd1,
    HitPitch = 2'd2
  } motor_hit_e;

endpackage

// ===== hdl/stepper_position_reply_parser_core.sv =====
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------------------------
// input     | in_valid_i / in_ready_o        | rx_byte_i
// output    | out_valid_o / out_ready_i      | frame_valid_o, frame_address_o, motor_hit_o,
//           |                                | frame_angle_o, yaw_angle_now_o,
//           |                                | pitch_angle_now_o
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One byte is accepted per cycle. The eighth byte of each frame yields one
// item that passes through a decode stage, then the multiply by 360 into the
// output register. Bytes that do not close a frame are always accepted; a
// closing byte waits only while both the decode stage and the output register
// are held by a stalled output. Reset clears the byte count, both stored
// angles and the valid flags, and loads the motor addresses to 1 and 2.
module stepper_position_reply_parser_core
  import spr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     frame_valid_o,
  output logic [7:0]               frame_address_o,
  output logic [1:0]               motor_hit_o,
  output logic signed [AngleW-1:0] frame_angle_o,
  output logic signed [AngleW-1:0] yaw_angle_now_o,
  output logic signed [AngleW-1:0] pitch_angle_now_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  logic [7:0]               yaw_addr_q;
  logic [7:0]               pitch_addr_q;
  logic [CntW-1:0]          byte_cnt_q;
  logic [7:0]               frame_q [FrameBytes-1];
  logic                     s1_valid_q;
  logic                     s1_ok_q;
  logic [7:0]               s1_addr_q;
  motor_hit_e               s1_hit_q;
  logic signed [PosW-1:0]   s1_pos_q;
  logic                     out_valid_q;
  logic                     out_ok_q;
  logic [7:0]               out_addr_q;
  motor_hit_e               out_hit_q;
  logic signed [AngleW-1:0] out_angle_q;
  logic signed [AngleW-1:0] yaw_q;
  logic signed [AngleW-1:0] pitch_q;

  logic                     last_byte;
  logic                     in_fire;
  logic                     s2_advance;
  logic                     s1_free;
  logic                     frame_ok;
  logic [PosW-1:0]          raw_pos;
  logic [PosW-1:0]          pos_w;
  motor_hit_e               hit_w;
  logic signed [AngleW-1:0] angle_w;
  reg_idx_e                 reg_sel;

  // Configuration port: always ready, word-aligned decode on address bit 2.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_addr_q   <= YawAddrReset;
      pitch_addr_q <= PitchAddrReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        RegYawAddr:   yaw_addr_q   <= pwdata[7:0];
        RegPitchAddr: pitch_addr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegYawAddr:   prdata = {{(DataW-8){1'b0}}, yaw_addr_q};
      RegPitchAddr: prdata = {{(DataW-8){1'b0}}, pitch_addr_q};
      default:      prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign last_byte   = (byte_cnt_q == CntW'(FrameBytes - 1));
  assign s2_advance  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_free     = !s1_valid_q || s2_advance;
  assign in_ready_o  = !last_byte || s1_free;
  assign in_fire     = in_valid_i && in_ready_o;

  // Byte counter, free running over frames from reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
    end else if (in_fire) begin
      byte_cnt_q <= last_byte ? '0 : byte_cnt_q + 1'b1;
    end
  end

  // Frame byte store; the closing byte is used directly.
  always_ff @(posedge clk_i) begin
    if (in_fire && !last_byte) begin
      frame_q[byte_cnt_q] <= rx_byte_i;
    end
  end

  // Decode of a completed frame: markers, signed position and target motor.
  always_comb begin
    frame_ok = (frame_q[1] == CmdByte) && (rx_byte_i == TailByte);
    raw_pos  = {frame_q[3], frame_q[4], frame_q[5], frame_q[6]};
    pos_w    = '0;
    hit_w    = HitNone;
    if (frame_ok) begin
      pos_w = (frame_q[2] == NegFlag) ? (PosW'(0) - raw_pos) : raw_pos;
      if (frame_q[0] == yaw_addr_q) begin
        hit_w = HitYaw;
      end else if (frame_q[0] == pitch_addr_q) begin
        hit_w = HitPitch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_fire && last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte) begin
      s1_ok_q   <= frame_ok;
      s1_addr_q <= frame_q[0];
      s1_hit_q  <= hit_w;
      s1_pos_q  <= $signed(pos_w);
    end
  end

  // Scale to degrees; the product always fits in the angle width.
  assign angle_w = AngleW'(s1_pos_q) * DegScale;

  // Output register and stored angles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      pitch_q     <= '0;
    end else begin
      if (s2_advance) begin
        out_valid_q <= 1'b1;
        if (s1_hit_q == HitYaw) begin
          yaw_q <= angle_w;
        end
        if (s1_hit_q == HitPitch) begin
          pitch_q <= angle_w;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_advance) begin
      out_ok_q    <= s1_ok_q;
      out_addr_q  <= s1_addr_q;
      out_hit_q   <= s1_hit_q;
      out_angle_q <= angle_w;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_valid_o     = out_ok_q;
  assign frame_address_o   = out_addr_q;
  assign motor_hit_o       = out_hit_q;
  assign frame_angle_o     = out_angle_q;
  assign yaw_angle_now_o   = yaw_q;
  assign pitch_angle_now_o = pitch_q;

endmodule

// ===== hdl/spr_checker.sv =====
`include "assert_macros.svh"

module spr_checker
  import spr_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     frame_valid_o,
  input logic [1:0]               motor_hit_o,
  input logic signed [AngleW-1:0] frame_angle_o,
  input logic signed [AngleW-1:0] yaw_angle_now_o,
  input logic signed [AngleW-1:0] pitch_angle_now_o
);

  // A motor update only comes from a frame whose markers matched.
  `SPR_ASSERT_IMP(a_hit_needs_valid, clk_i, rst_ni,
                  out_valid_o && motor_hit_o != HitNone, frame_valid_o,
                  "motor update from a bad frame")

  // A bad frame reports a zero angle.
  `SPR_ASSERT_IMP(a_bad_frame_zero, clk_i, rst_ni,
                  out_valid_o && !frame_valid_o, frame_angle_o == '0,
                  "bad frame with non-zero angle")

  // The updated motor shows the angle of this frame.
  `SPR_ASSERT_IMP(a_yaw_tracks, clk_i, rst_ni,
                  out_valid_o && motor_hit_o == HitYaw, yaw_angle_now_o == frame_angle_o,
                  "yaw angle not taken from frame")

  `SPR_ASSERT_IMP(a_pitch_tracks, clk_i, rst_ni,
                  out_valid_o && motor_hit_o == HitPitch, pitch_angle_now_o == frame_angle_o,
                  "pitch angle not taken from frame")

  // A stalled item keeps its result.
  `SPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   out_valid_o && !out_ready_i, out_valid_o && $stable(frame_angle_o),
                   "stalled item changed")

endmodule

bind stepper_position_reply_parser_core spr_checker u_spr_checker (.*);

// ===== bench/tb_stepper_position_reply_parser_core.sv =====
`timescale 1ns / 1ps

module tb_stepper_position_reply_parser_core;
  import spr_pkg::*;

  // One expected reply, as the parser should report a completed frame.
  typedef struct {
    logic                     frame_ok;
    logic [7:0]               address;
    motor_hit_e               hit;
    logic signed [AngleW-1:0] angle;
    logic signed [AngleW-1:0] yaw;
    logic signed [AngleW-1:0] pitch;
  } frame_reply_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               rx_byte_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     frame_valid_o;
  logic [7:0]               frame_address_o;
  logic [1:0]               motor_hit_o;
  logic signed [AngleW-1:0] frame_angle_o;
  logic signed [AngleW-1:0] yaw_angle_now_o;
  logic signed [AngleW-1:0] pitch_angle_now_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  // Shadow state of the parser, updated as each byte is accepted.
  logic [2:0]               frame_pos;
  logic [7:0]               frame_buf [0:FrameBytes-2];
  logic signed [AngleW-1:0] yaw_store;
  logic signed [AngleW-1:0] pitch_store;
  logic [7:0]               yaw_addr_cfg;
  logic [7:0]               pitch_addr_cfg;

  frame_reply_t pending_replies [$];

  int  mismatches;
  int  bytes_sent;
  int  frames_closed;
  int  replies_checked;
  int  rx_hold_cycles;
  bit  tx_idle_en;
  bit  rx_idle_en;

  stepper_position_reply_parser_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_valid_o     (frame_valid_o),
    .frame_address_o   (frame_address_o),
    .motor_hit_o       (motor_hit_o),
    .frame_angle_o     (frame_angle_o),
    .yaw_angle_now_o   (yaw_angle_now_o),
    .pitch_angle_now_o (pitch_angle_now_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard limit on the length of the run.
  initial begin
    #2ms;
    $display("tb_stepper_position_reply_parser_core: FAIL");
    $finish;
  end

  // Updates the shadow state with one accepted byte and, when the byte closes
  // a frame, queues the reply that the parser should produce for it.
  task automatic parse_byte(input logic [7:0] b);
    frame_reply_t reply;
    logic [31:0]  position;
    if (frame_pos < FrameBytes - 1) begin
      frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 3'd1;
    end else begin
      frame_pos      = '0;
      reply.frame_ok = (frame_buf[1] == CmdByte) && (b == TailByte);
      reply.address  = frame_buf[0];
      reply.hit      = HitNone;
      reply.angle    = '0;
      if (reply.frame_ok) begin
        position = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
        // The sign flag negates with 32-bit wrap, so the most negative
        // position maps onto itself.
        if (frame_buf[2] == NegFlag) position = 32'd0 - position;
        reply.angle = $signed(position) * DegScale;
        // Yaw takes precedence when both addresses match.
        if (frame_buf[0] == yaw_addr_cfg) begin
          yaw_store = reply.angle;
          reply.hit = HitYaw;
        end else if (frame_buf[0] == pitch_addr_cfg) begin
          pitch_store = reply.angle;
          reply.hit   = HitPitch;
        end
      end
      reply.yaw   = yaw_store;
      reply.pitch = pitch_store;
      pending_replies.push_back(reply);
      frames_closed++;
    end
  endtask

  // Offers one byte, after a random gap when tx_idle_en is set, and returns once it has been accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    parse_byte(b);
  endtask

  // Pads to a frame boundary with junk, then sends one complete frame.
  task automatic send_frame(input logic [7:0] address, input logic [7:0] cmd,
                            input logic [7:0] sign, input logic [31:0] position,
                            input logic [7:0] tail);
    while (frame_pos != 0) send_byte(8'($urandom));
    send_byte(address);
    send_byte(cmd);
    send_byte(sign);
    send_byte(position[31:24]);
    send_byte(position[23:16]);
    send_byte(position[15:8]);
    send_byte(position[7:0]);
    send_byte(tail);
  endtask

  // Stops offering bytes until every queued reply has arrived, then idles on as a
  // margin.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes a motor address register over the configuration port and reads it
  // back. The upper data bits are random and must be ignored.
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == RegYawAddr) yaw_addr_cfg = value;
    else pitch_addr_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(value)) begin
      $error("prdata: expected %0h, got %0h", DataW'(value), prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed frames aimed at the configured motors, with occasional
  // corrupt markers and odd sign bytes; half carry an extreme position.
  task automatic send_random_frame();
    logic [7:0]  address;
    logic [7:0]  cmd;
    logic [7:0]  sign;
    logic [7:0]  tail;
    logic [31:0] position;
    int          pick;
    pick    = $urandom_range(0, 9);
    address = (pick < 4) ? yaw_addr_cfg : (pick < 8) ? pitch_addr_cfg : 8'($urandom);
    cmd     = ($urandom_range(0, 7) != 0) ? CmdByte : 8'($urandom);
    tail    = ($urandom_range(0, 7) != 0) ? TailByte : 8'($urandom);
    case ($urandom_range(0, 3))
      0, 1:    sign = NegFlag;
      2:       sign = 8'h00;
      default: sign = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       position = 32'h7FFF_FFFF;
      1:       position = 32'h8000_0000;
      2:       position = 32'h0000_0000;
      3:       position = 32'hFFFF_FFFF;
      default: position = $urandom;
    endcase
    send_frame(address, cmd, sign, position, tail);
  endtask

  // Directed frames straight after reset: largest and most negative angles,
  // and a frame with both markers wrong.
  task automatic test_reset_frames();
    send_frame(YawAddrReset, CmdByte, 8'h00, 32'h7FFF_FFFF, TailByte);
    send_frame(PitchAddrReset, CmdByte, NegFlag, 32'h8000_0000, TailByte);
    send_frame(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // Equal motor addresses, where yaw must win, and a valid frame for a motor
  // that is not configured.
  task automatic test_address_tie();
    write_reg(RegYawAddr, 8'h00);
    write_reg(RegPitchAddr, 8'h00);
    send_frame(8'h00, CmdByte, NegFlag, 32'hFFFF_FFFF, TailByte);
    send_frame(8'hFF, CmdByte, 8'h00, 32'h0012_3456, TailByte);
  endtask

  // Random traffic under one address setting, with stray bytes that break
  // frame alignment and the odd pause until the parser has drained.
  task automatic test_random_traffic(input logic [7:0] yaw_addr,
                                     input logic [7:0] pitch_addr, input int frames);
    write_reg(RegYawAddr, yaw_addr);
    write_reg(RegPitchAddr, pitch_addr);
    repeat (frames) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end
      send_random_frame();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  // Bytes and replies at full rate on both sides.
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (10) send_random_frame();
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Long receiver hold-off while frames keep coming, so that the parser fills
  // up and has to hold off closing bytes.
  task automatic test_output_backpressure();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 150;
    repeat (6) send_random_frame();
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  // Receiver: random stalls per item when rx_idle_en is set, plus a long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && rx_hold_cycles == 0);
    end
  end

  // Compares each accepted reply with the oldest expected one.
  always @(posedge clk_i) begin : check_replies
    frame_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $error("reply item received with none expected");
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (frame_valid_o !== want.frame_ok) begin
          $error("frame_valid: expected %0d, got %0d", want.frame_ok, frame_valid_o);
          mismatches++;
        end
        if (frame_address_o !== want.address) begin
          $error("frame_address: expected %0h, got %0h", want.address, frame_address_o);
          mismatches++;
        end
        if (motor_hit_o !== want.hit) begin
          $error("motor_hit: expected %0d, got %0d", want.hit, motor_hit_o);
          mismatches++;
        end
        if (frame_angle_o !== want.angle) begin
          $error("frame_angle: expected %0d, got %0d", want.angle, frame_angle_o);
          mismatches++;
        end
        if (yaw_angle_now_o !== want.yaw) begin
          $error("yaw_angle_now: expected %0d, got %0d", want.yaw, yaw_angle_now_o);
          mismatches++;
        end
        if (pitch_angle_now_o !== want.pitch) begin
          $error("pitch_angle_now: expected %0d, got %0d", want.pitch, pitch_angle_now_o);
          mismatches++;
        end
      end
    end
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    frame_pos      = '0;
    yaw_store      = '0;
    pitch_store    = '0;
    yaw_addr_cfg   = YawAddrReset;
    pitch_addr_cfg = PitchAddrReset;
    mismatches     = 0;
    bytes_sent     = 0;
    frames_closed  = 0;
    replies_checked = 0;
    rx_hold_cycles = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_frames();
    test_address_tie();
    test_random_traffic(YawAddrReset, PitchAddrReset, 10);
    test_random_traffic(8'hFF, 8'h00, 10);
    test_back_to_back();
    test_random_traffic(8'h00, 8'hFF, 10);
    test_output_backpressure();
    test_random_traffic(8'h5A, 8'h5A, 10);
    test_random_traffic(8'($urandom), 8'($urandom), 10);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes closing %0d frames; %0d replies checked.",
             bytes_sent, frames_closed, replies_checked);
    $display("Covered extreme and equal motor addresses, bad markers, misalignment, stalls.");
    if (mismatches == 0) begin
      $display("tb_stepper_position_reply_parser_core: PASS");
    end else begin
      $display("tb_stepper_position_reply_parser_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== stepper_position_reply_parser_core.f =====
+incdir+hdl
hdl/spr_pkg.sv
hdl/stepper_position_reply_parser_core.sv
hdl/spr_checker.sv
bench/tb_stepper_position_reply_parser_core.sv
